@@ design/fccrp_pkg.sv @@
// Shared constants, codes and types of the FAT cluster chain read planner.
package fccrp_pkg;

  // Sizes and limits.
  localparam int unsigned FAT_ENTRIES_DEF = 4096;
  localparam int unsigned STAGING_BYTES   = 4096;
  localparam int unsigned MAX_READ_BYTES  = 16384;
  localparam int unsigned MAX_RESULTS     = 33;
  localparam int unsigned ENTRY_W         = 28;

  // Cluster markers.
  localparam logic [ENTRY_W-1:0] EOC_MARK    = 28'hFFFFFF8;
  localparam logic [ENTRY_W-1:0] CHAIN_END   = 28'hFFFFFFF;
  localparam logic [ENTRY_W-1:0] MIN_CLUSTER = 28'd2;

  // Legal range of the sector size exponent.
  localparam logic [3:0] BPS_LOG2_MIN = 4'd9;
  localparam logic [3:0] BPS_LOG2_MAX = 4'd12;

  // Commands.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_OPEN = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_BAD_CL   = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_DATA_BASE     = 2'd0;
  localparam logic [1:0] REG_SPC_LOG2      = 2'd1;
  localparam logic [1:0] REG_BPS_LOG2      = 2'd2;
  localparam logic [1:0] REG_START_CLUSTER = 2'd3;

  // Configuration seen by the planner.
  typedef struct packed {
    logic [31:0]        data_base;
    logic [2:0]         spc_log2;
    logic [3:0]         bps_log2;
    logic [ENTRY_W-1:0] start_cluster;
  } cfg_t;

endpackage

@@ design/fat_cluster_chain_read_planner.sv @@
// Top level: FAT cluster chain read planner, chunking reads along the cluster chain.
// Load and open commands give no result; the block stays idle and ready for the next item.
// A read takes each chunk through ST_CALC, which sizes it, ST_ADDR, which forms the sector and
// reads the FAT entry, and ST_FETCH, which takes the FAT data and registers the result.
// ST_FETCH waits while the output is stalled; a stalled output holds its result.
// Reset clears control state and the current cluster to end of chain; the FAT is not cleared.
module fat_cluster_chain_read_planner #(
  parameter int unsigned FAT_ENTRIES = fccrp_pkg::FAT_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [11:0] fat_index_i,
  input  logic [31:0] fat_value_i,
  input  logic [14:0] byte_count_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [32:0] sector_o,
  output logic [11:0] sec_skip_o,
  output logic [14:0] copy_bytes_o,
  output logic [5:0]  sector_count_o,
  output logic        staged_o,
  output logic [1:0]  status_o,
  output logic [14:0] total_bytes_o,
  output logic        last_o
);

  localparam int unsigned EntryW = fccrp_pkg::ENTRY_W;
  localparam int unsigned AddrW  = (FAT_ENTRIES > 1) ? $clog2(FAT_ENTRIES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_ADDR  = 4'b0100,
    ST_FETCH = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_BAD_CL,
    KIND_DATA
  } kind_e;

  fccrp_pkg::cfg_t cfg;

  state_e state_q, state_d;

  // Persistent chain position.
  logic [EntryW-1:0] cur_q, cur_d;
  logic [18:0]       offset_q, offset_d;

  // Per-read progress.
  logic [14:0] rem_q, rem_d;
  logic [14:0] total_q, total_d;
  logic [5:0]  n_q, n_d;

  // Chunk pipeline registers.
  kind_e       kind_q, kind_d;
  logic [14:0] take_q, take_d;
  logic [18:0] off_q, off_d;
  logic [18:0] off_sec_q, off_sec_d;
  logic [11:0] so_q, so_d;
  logic [19:0] cs_q, cs_d;
  logic [32:0] sec_q, sec_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        staged_q, staged_d;
  logic        ovf_q, ovf_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [32:0] o_sector_q, o_sector_d;
  logic [11:0] o_so_q, o_so_d;
  logic [14:0] o_copy_q, o_copy_d;
  logic [5:0]  o_cnt_q, o_cnt_d;
  logic        o_staged_q, o_staged_d;
  logic [1:0]  o_status_q, o_status_d;
  logic [14:0] o_total_q, o_total_d;
  logic        o_last_q, o_last_d;

  // Memory ports.
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic              ram_re;
  logic [EntryW-1:0] ram_rdata;
  logic [31:0]       idx_ext;

  // Derived configuration.
  logic [3:0]  bl;
  logic [2:0]  sl;
  logic [4:0]  csl;
  logic [19:0] cs;
  logic [12:0] bps;

  // Datapath intermediates.
  logic        in_acc;
  logic        out_free;
  logic [14:0] bc_sat;
  logic [18:0] off_c;
  logic [19:0] avail;
  logic [32:0] cl_base;
  logic [15:0] cnt_sum;
  logic [15:0] cnt_full;
  logic [31:0] stage_bytes;
  logic        staged_c;
  logic [19:0] new_off;
  logic        boundary;
  logic [EntryW-1:0] next_cur;
  logic [14:0] new_rem;
  logic [14:0] new_total;
  logic [5:0]  new_n;
  logic        run_last;

  fccrp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // FAT store: loads write it, the chunk pipeline reads the current cluster's entry.
  assign idx_ext   = {20'd0, fat_index_i};
  assign ram_waddr = idx_ext[AddrW-1:0];
  assign ram_we    = in_acc && (command_i == fccrp_pkg::CMD_LOAD) &&
                     (idx_ext < 32'(FAT_ENTRIES));
  assign ram_re    = (state_q == ST_ADDR);

  fccrp_ram #(
    .WIDTH (EntryW),
    .DEPTH (FAT_ENTRIES)
  ) u_fat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (fat_value_i[EntryW-1:0]),
    .re_i    (ram_re),
    .raddr_i (cur_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sector and cluster sizes from the configuration.
  always_comb begin
    priority if (cfg.bps_log2 < fccrp_pkg::BPS_LOG2_MIN) begin
      bl = fccrp_pkg::BPS_LOG2_MIN;
    end else if (cfg.bps_log2 > fccrp_pkg::BPS_LOG2_MAX) begin
      bl = fccrp_pkg::BPS_LOG2_MAX;
    end else begin
      bl = cfg.bps_log2;
    end
  end

  assign sl  = cfg.spc_log2;
  assign csl = {2'd0, sl} + {1'b0, bl};
  assign cs  = 20'd1 << csl;
  assign bps = 13'd1 << bl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign bc_sat     = (byte_count_i > 15'(fccrp_pkg::MAX_READ_BYTES)) ?
                      15'(fccrp_pkg::MAX_READ_BYTES) : byte_count_i;

  // Chunk sizing: offset in the cluster, bytes available and bytes taken.
  assign off_c = offset_q & cs[18:0] - 19'd1;
  assign avail = cs - {1'b0, off_c};

  // Sector address and sector count of the chunk.
  assign cl_base     = {5'd0, cur_q - fccrp_pkg::MIN_CLUSTER} << sl;
  assign cnt_sum     = {4'd0, so_q} + {1'b0, take_q} + {3'd0, bps} - 16'd1;
  assign cnt_full    = cnt_sum >> bl;
  assign staged_c    = (so_q != 12'd0) || ({1'b0, take_q} < {3'd0, bps});
  assign stage_bytes = {26'd0, cnt_full[5:0]} << bl;

  // Advance of the chain after a delivered chunk.
  assign new_off   = {1'b0, off_q} + {5'd0, take_q};
  assign boundary  = (new_off == cs_q);
  assign next_cur  = boundary ? ram_rdata : cur_q;
  assign new_rem   = rem_q - take_q;
  assign new_total = total_q + take_q;
  assign new_n     = n_q + 6'd1;
  assign run_last  = (new_rem == 15'd0) || (next_cur >= fccrp_pkg::EOC_MARK) ||
                     (new_n >= 6'(fccrp_pkg::MAX_RESULTS));

  // Sequencer and datapath.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    offset_d    = offset_q;
    rem_d       = rem_q;
    total_d     = total_q;
    n_d         = n_q;
    kind_d      = kind_q;
    take_d      = take_q;
    off_d       = off_q;
    off_sec_d   = off_sec_q;
    so_d        = so_q;
    cs_d        = cs_q;
    sec_d       = sec_q;
    cnt_d       = cnt_q;
    staged_d    = staged_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_sector_d  = o_sector_q;
    o_so_d      = o_so_q;
    o_copy_d    = o_copy_q;
    o_cnt_d     = o_cnt_q;
    o_staged_d  = o_staged_q;
    o_status_d  = o_status_q;
    o_total_d   = o_total_q;
    o_last_d    = o_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (command_i == fccrp_pkg::CMD_OPEN) begin
            cur_d    = cfg.start_cluster;
            offset_d = 19'd0;
          end else if (command_i == fccrp_pkg::CMD_READ) begin
            rem_d   = bc_sat;
            total_d = 15'd0;
            n_d     = 6'd0;
            state_d = ST_CALC;
          end
        end
      end

      // Classify the step and size the chunk.
      ST_CALC: begin
        if ((rem_q == 15'd0) || (cur_q >= fccrp_pkg::EOC_MARK)) begin
          kind_d = KIND_EMPTY;
        end else if ((cur_q < fccrp_pkg::MIN_CLUSTER) ||
                     ({4'd0, cur_q} >= 32'(FAT_ENTRIES))) begin
          kind_d = KIND_BAD_CL;
        end else begin
          kind_d = KIND_DATA;
        end
        take_d    = ({5'd0, rem_q} < avail) ? rem_q : avail[14:0];
        off_d     = off_c;
        off_sec_d = off_c >> bl;
        so_d      = off_c[11:0] & (bps[11:0] - 12'd1);
        cs_d      = cs;
        state_d   = ST_ADDR;
      end

      // Sector address, sector count and staging check; FAT read is issued here.
      ST_ADDR: begin
        sec_d    = {1'b0, cfg.data_base} + cl_base + {14'd0, off_sec_q};
        cnt_d    = cnt_full[5:0];
        staged_d = staged_c;
        ovf_d    = staged_c && (stage_bytes > 32'(fccrp_pkg::STAGING_BYTES));
        state_d  = ST_FETCH;
      end

      // Emit the result and follow the chain.
      ST_FETCH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_sector_d  = 33'd0;
          o_so_d      = 12'd0;
          o_copy_d    = 15'd0;
          o_cnt_d     = 6'd0;
          o_staged_d  = 1'b0;
          o_status_d  = fccrp_pkg::STATUS_OK;
          o_total_d   = total_q;
          o_last_d    = 1'b1;
          state_d     = ST_IDLE;
          if (kind_q == KIND_EMPTY) begin
            o_total_d = 15'd0;
          end else if (kind_q == KIND_BAD_CL) begin
            o_status_d = fccrp_pkg::STATUS_BAD_CL;
          end else if (ovf_q) begin
            // Refused staged chunk: report it but do not advance.
            o_sector_d = sec_q;
            o_so_d     = so_q;
            o_cnt_d    = cnt_q;
            o_staged_d = 1'b1;
            o_status_d = fccrp_pkg::STATUS_OVERFLOW;
          end else begin
            o_sector_d = sec_q;
            o_so_d     = so_q;
            o_copy_d   = take_q;
            o_cnt_d    = cnt_q;
            o_staged_d = staged_q;
            o_total_d  = new_total;
            o_last_d   = run_last;
            cur_d      = next_cur;
            offset_d   = boundary ? 19'd0 : new_off[18:0];
            rem_d      = new_rem;
            total_d    = new_total;
            n_d        = new_n;
            state_d    = run_last ? ST_IDLE : ST_CALC;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= fccrp_pkg::CHAIN_END;
      offset_q    <= 19'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    total_q    <= total_d;
    n_q        <= n_d;
    kind_q     <= kind_d;
    take_q     <= take_d;
    off_q      <= off_d;
    off_sec_q  <= off_sec_d;
    so_q       <= so_d;
    cs_q       <= cs_d;
    sec_q      <= sec_d;
    cnt_q      <= cnt_d;
    staged_q   <= staged_d;
    ovf_q      <= ovf_d;
    o_sector_q <= o_sector_d;
    o_so_q     <= o_so_d;
    o_copy_q   <= o_copy_d;
    o_cnt_q    <= o_cnt_d;
    o_staged_q <= o_staged_d;
    o_status_q <= o_status_d;
    o_total_q  <= o_total_d;
    o_last_q   <= o_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sector_o       = o_sector_q;
  assign sec_skip_o     = o_so_q;
  assign copy_bytes_o   = o_copy_q;
  assign sector_count_o = o_cnt_q;
  assign staged_o       = o_staged_q;
  assign status_o       = o_status_q;
  assign total_bytes_o  = o_total_q;
  assign last_o         = o_last_q;

endmodule

@@ design/fccrp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module fccrp_ram #(
  parameter int unsigned WIDTH = fccrp_pkg::ENTRY_W,
  parameter int unsigned DEPTH = fccrp_pkg::FAT_ENTRIES_DEF,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fccrp_cfg.sv @@
// APB-style configuration registers of the FAT cluster chain read planner.
module fccrp_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fccrp_pkg::cfg_t    cfg_o
);

  fccrp_pkg::cfg_t cfg_q;
  fccrp_pkg::cfg_t cfg_d;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        fccrp_pkg::REG_DATA_BASE:     cfg_d.data_base     = pwdata;
        fccrp_pkg::REG_SPC_LOG2:      cfg_d.spc_log2      = pwdata[2:0];
        fccrp_pkg::REG_BPS_LOG2:      cfg_d.bps_log2      = pwdata[3:0];
        fccrp_pkg::REG_START_CLUSTER: cfg_d.start_cluster = pwdata[fccrp_pkg::ENTRY_W-1:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_base     <= 32'd0;
      cfg_q.spc_log2      <= 3'd3;
      cfg_q.bps_log2      <= 4'd9;
      cfg_q.start_cluster <= fccrp_pkg::MIN_CLUSTER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read mux.
  always_comb begin
    unique case (reg_idx)
      fccrp_pkg::REG_DATA_BASE:     prdata = cfg_q.data_base;
      fccrp_pkg::REG_SPC_LOG2:      prdata = {29'd0, cfg_q.spc_log2};
      fccrp_pkg::REG_BPS_LOG2:      prdata = {28'd0, cfg_q.bps_log2};
      fccrp_pkg::REG_START_CLUSTER: prdata = {4'd0, cfg_q.start_cluster};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ dv/fat_cluster_chain_read_planner_tb.sv @@
// Testbench for the FAT cluster chain read planner: directed and random items against a predictor.
`timescale 1ns / 100ps

module fat_cluster_chain_read_planner_tb;

  // Command code that the package leaves unnamed: the block does nothing with it.
  localparam logic [1:0] CMD_NOP = 2'd3;

  // One planned chunk, in the bit order of the output ports.
  typedef struct packed {
    logic [32:0] sector;
    logic [11:0] sec_skip;
    logic [14:0] copy_bytes;
    logic [5:0]  sector_count;
    logic        staged;
    logic [1:0]  status;
    logic [14:0] total_bytes;
    logic        last;
  } chunk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = CMD_NOP;
  logic [11:0] fat_index_i = '0;
  logic [31:0] fat_value_i = '0;
  logic [14:0] byte_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [32:0] sector_o;
  logic [11:0] sec_skip_o;
  logic [14:0] copy_bytes_o;
  logic [5:0]  sector_count_o;
  logic        staged_o;
  logic [1:0]  status_o;
  logic [14:0] total_bytes_o;
  logic        last_o;

  // Shadow of the table, the walk position and the registers.
  logic [27:0] fat_shadow [fccrp_pkg::FAT_ENTRIES_DEF];
  bit          fat_loaded [fccrp_pkg::FAT_ENTRIES_DEF];
  logic [27:0] cur_cluster = fccrp_pkg::CHAIN_END;
  logic [18:0] cluster_off = '0;
  logic [31:0] cfg_data_base = '0;
  logic [2:0]  cfg_spc_log2 = 3'd3;
  logic [3:0]  cfg_bps_log2 = 4'd9;
  logic [27:0] cfg_start_cluster = fccrp_pkg::MIN_CLUSTER;

  chunk_t      chunks_due [$];
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold = 0;

  fat_cluster_chain_read_planner i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .fat_index_i    (fat_index_i),
    .fat_value_i    (fat_value_i),
    .byte_count_i   (byte_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sector_o       (sector_o),
    .sec_skip_o     (sec_skip_o),
    .copy_bytes_o   (copy_bytes_o),
    .sector_count_o (sector_count_o),
    .staged_o       (staged_o),
    .status_o       (status_o),
    .total_bytes_o  (total_bytes_o),
    .last_o         (last_o)
  );

  // Clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic string chunk_text(chunk_t c);
    return $sformatf({"sector=%h skip=%0d copy=%0d nsec=%0d staged=%0b status=%0d",
                      " total=%0d last=%0b"},
                     c.sector, c.sec_skip, c.copy_bytes, c.sector_count, c.staged,
                     c.status, c.total_bytes, c.last);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Walks one read along the chain. With commit set, it queues the chunks and moves the
  // walk position; otherwise it only looks ahead. Returns the first table entry the walk
  // would need that was never loaded, or -1.
  function automatic int plan_read(input logic [14:0] count, input bit commit);
    int unsigned bps_log2, cs_bytes, bps, rem, total, off, take, soff, nsec;
    logic [27:0] cl;
    logic [18:0] pos;
    logic [32:0] sec;
    bit          stg, stop;
    int          missing;
    chunk_t      c;
    chunk_t      got [$];
    bps_log2 = (cfg_bps_log2 < fccrp_pkg::BPS_LOG2_MIN) ? fccrp_pkg::BPS_LOG2_MIN :
               (cfg_bps_log2 > fccrp_pkg::BPS_LOG2_MAX) ? fccrp_pkg::BPS_LOG2_MAX :
               cfg_bps_log2;
    cs_bytes = 1 << (cfg_spc_log2 + bps_log2);
    bps = 1 << bps_log2;
    rem = (count > fccrp_pkg::MAX_READ_BYTES) ? fccrp_pkg::MAX_READ_BYTES : count;
    total = 0;
    cl = cur_cluster;
    pos = cluster_off;
    missing = -1;
    stop = 1'b0;
    while (!stop && rem > 0 && cl < fccrp_pkg::EOC_MARK &&
           got.size() < fccrp_pkg::MAX_RESULTS) begin
      c = '0;
      if (cl < fccrp_pkg::MIN_CLUSTER || cl >= 28'(fccrp_pkg::FAT_ENTRIES_DEF)) begin
        // Cluster outside the table: report how far the read got and stop.
        c.status = fccrp_pkg::STATUS_BAD_CL;
        c.total_bytes = 15'(total);
        got.push_back(c);
        stop = 1'b1;
      end else begin
        off = pos & (cs_bytes - 1);
        take = (rem < cs_bytes - off) ? rem : cs_bytes - off;
        sec = 33'(cfg_data_base) + (33'(cl - fccrp_pkg::MIN_CLUSTER) << cfg_spc_log2) +
              33'(off >> bps_log2);
        soff = off & (bps - 1);
        stg = (soff != 0) || (take < bps);
        nsec = (soff + take + bps - 1) >> bps_log2;
        c.sector = sec;
        c.sec_skip = 12'(soff);
        c.sector_count = 6'(nsec);
        c.staged = stg;
        if (stg && (nsec << bps_log2) > fccrp_pkg::STAGING_BYTES) begin
          // Staging buffer too small: the chunk is refused and the position stays.
          c.status = fccrp_pkg::STATUS_OVERFLOW;
          c.total_bytes = 15'(total);
          got.push_back(c);
          stop = 1'b1;
        end else begin
          total += take;
          rem -= take;
          c.copy_bytes = 15'(take);
          c.total_bytes = 15'(total);
          got.push_back(c);
          off += take;
          // End of the cluster: follow the table.
          if (off == cs_bytes) begin
            if (!fat_loaded[cl[11:0]]) begin
              missing = int'(cl);
              stop = 1'b1;
            end else begin
              off = 0;
              cl = fat_shadow[cl[11:0]];
            end
          end
          pos = 19'(off);
        end
      end
    end
    if (got.size() == 0) begin
      got.push_back('0);
    end
    got[got.size() - 1].last = 1'b1;
    if (commit && missing < 0) begin
      foreach (got[i]) chunks_due.push_back(got[i]);
      cur_cluster = cl;
      cluster_off = pos;
    end
    return missing;
  endfunction

  // Updates the shadow for one accepted item.
  function automatic void apply_item(input logic [1:0] cmd, input logic [11:0] idx,
                                     input logic [31:0] val, input logic [14:0] count);
    case (cmd)
      fccrp_pkg::CMD_LOAD: begin
        fat_shadow[idx] = val[27:0];
        fat_loaded[idx] = 1'b1;
      end
      fccrp_pkg::CMD_OPEN: begin
        cur_cluster = cfg_start_cluster;
        cluster_off = '0;
      end
      fccrp_pkg::CMD_READ: begin
        void'(plan_read(count, 1'b1));
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one item after a random gap and waits until it is accepted.
  task automatic send_item(input logic [1:0] cmd, input logic [11:0] idx,
                           input logic [31:0] val, input logic [14:0] count);
    int unsigned gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    fat_index_i <= idx;
    fat_value_i <= val;
    byte_count_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(cmd, idx, val, count);
  endtask

  // Random next-cluster entry: mostly a small pool, sometimes end of chain or out of range.
  function automatic logic [31:0] random_link();
    int unsigned pick;
    logic [27:0] nxt;
    pick = $urandom_range(99);
    if (pick < 70) nxt = 28'($urandom_range(2, 60));
    else if (pick < 78) nxt = 28'($urandom_range(2, 4095));
    else if (pick < 90) nxt = fccrp_pkg::EOC_MARK + 28'($urandom_range(0, 7));
    else if (pick < 94) nxt = 28'($urandom_range(0, 1));
    else nxt = 28'($urandom_range(4096, 32'h0FFF_FFF7));
    return {4'($urandom), nxt};
  endfunction

  // Sends a read, first loading every table entry the walk will look up.
  task automatic read_bytes(input logic [14:0] count);
    int missing;
    missing = plan_read(count, 1'b0);
    while (missing >= 0) begin
      send_item(fccrp_pkg::CMD_LOAD, 12'(missing), random_link(), 15'($urandom));
      missing = plan_read(count, 1'b0);
    end
    send_item(fccrp_pkg::CMD_READ, 12'($urandom), $urandom, count);
  endtask

  // Stops offering items and waits until the block has delivered everything.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One transfer on the configuration port.
  task automatic apb_xfer(input bit wr, input logic [1:0] reg_idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {reg_idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all four registers and reads each one back.
  task automatic set_config(input logic [31:0] ds, input logic [2:0] spc, input logic [3:0] bpsl,
                            input logic [27:0] sc);
    logic [1:0]  regs [4];
    logic [31:0] vals [4];
    logic [31:0] masks [4];
    logic [31:0] rd;
    regs = '{fccrp_pkg::REG_DATA_BASE, fccrp_pkg::REG_SPC_LOG2, fccrp_pkg::REG_BPS_LOG2,
             fccrp_pkg::REG_START_CLUSTER};
    vals = '{ds, 32'(spc), 32'(bpsl), 32'(sc)};
    masks = '{32'hFFFF_FFFF, 32'h7, 32'hF, 32'h0FFF_FFFF};
    for (int i = 0; i < 4; i++) begin
      apb_xfer(1'b1, regs[i], vals[i], rd);
      apb_xfer(1'b0, regs[i], '0, rd);
      if ((rd & masks[i]) !== vals[i]) begin
        note_mismatch($sformatf("register %0d readback: expected %h got %h",
                                regs[i], vals[i], rd));
      end
    end
    cfg_data_base = ds;
    cfg_spc_log2 = spc;
    cfg_bps_log2 = bpsl;
    cfg_start_cluster = sc;
  endtask

  task automatic random_config();
    int unsigned pick;
    logic [31:0] ds;
    logic [27:0] sc;
    pick = $urandom_range(99);
    ds = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
    pick = $urandom_range(99);
    if (pick < 80) sc = 28'($urandom_range(2, 60));
    else if (pick < 88) sc = fccrp_pkg::CHAIN_END;
    else if (pick < 94) sc = 28'($urandom_range(4096, 32'h0FFF_FFF7));
    else sc = 28'($urandom_range(2, 4095));
    set_config(ds, 3'($urandom_range(0, 7)), 4'($urandom_range(9, 12)), sc);
  endtask

  // Reads before any open, the no-op command and a zero-byte read.
  task automatic test_empty_reads();
    read_bytes(15'd100);
    send_item(CMD_NOP, 12'hFFF, 32'hFFFF_FFFF, 15'h7FFF);
    send_item(fccrp_pkg::CMD_OPEN, 12'h000, 32'h0, 15'd0);
    read_bytes(15'd0);
  endtask

  // Chain 2 -> 3 -> 4095 -> out of range, walked with the reset configuration.
  task automatic test_chain_walk();
    send_item(fccrp_pkg::CMD_LOAD, 12'd2, 32'hF000_0003, 15'd0);
    send_item(fccrp_pkg::CMD_LOAD, 12'd3, 32'h0000_0FFF, 15'd0);
    send_item(fccrp_pkg::CMD_LOAD, 12'hFFF, 32'hFFFF_1388, 15'd0);
    send_item(fccrp_pkg::CMD_LOAD, 12'd0, 32'h0, 15'd0);
    send_item(fccrp_pkg::CMD_OPEN, 12'd0, 32'h0, 15'd0);
    read_bytes(15'd100);
    read_bytes(15'd412);
    read_bytes(15'd3584);
    // Long request saturates, runs through two clusters and hits the bad one.
    read_bytes(15'h7FFF);
    read_bytes(15'd10);
  endtask

  // Misaligned chunk larger than the staging buffer, refused twice.
  task automatic test_staging_overflow();
    wait_idle();
    set_config(32'hFFFF_FFFF, 3'd4, 4'd9, fccrp_pkg::MIN_CLUSTER);
    send_item(fccrp_pkg::CMD_OPEN, 12'd0, 32'h0, 15'd0);
    read_bytes(15'd100);
    read_bytes(15'd8000);
    read_bytes(15'd16384);
  endtask

  // Largest cluster and sector sizes, start at end of chain, last entry and beyond the table.
  task automatic test_config_extremes();
    wait_idle();
    set_config(32'h0, 3'd7, 4'd12, fccrp_pkg::CHAIN_END);
    send_item(fccrp_pkg::CMD_OPEN, 12'd0, 32'h0, 15'd0);
    read_bytes(15'd50);
    wait_idle();
    set_config(32'h0, 3'd7, 4'd12, 28'd4095);
    send_item(fccrp_pkg::CMD_OPEN, 12'd0, 32'h0, 15'd0);
    read_bytes(15'd16384);
    wait_idle();
    set_config(32'h0, 3'd0, 4'd9, 28'd4096);
    send_item(fccrp_pkg::CMD_OPEN, 12'd0, 32'h0, 15'd0);
    read_bytes(15'd1);
  endtask

  // Smallest clusters on a self loop: a misaligned full read gives the most chunks.
  task automatic test_max_results();
    wait_idle();
    set_config($urandom, 3'd0, 4'd9, fccrp_pkg::MIN_CLUSTER);
    send_item(fccrp_pkg::CMD_LOAD, 12'd2, 32'h0000_0002, 15'd0);
    send_item(fccrp_pkg::CMD_OPEN, 12'd0, 32'h0, 15'd0);
    read_bytes(15'd1);
    read_bytes(15'd16384);
  endtask

  // Receiver holds off while long reads keep coming, then the sender waits for the drain.
  task automatic test_backpressure();
    wait_idle();
    @(negedge clk_i);
    rx_hold = 400;
    @(posedge clk_i);
    send_item(fccrp_pkg::CMD_OPEN, 12'd0, 32'h0, 15'd0);
    repeat (4) read_bytes(15'd16384);
    wait_idle();
  endtask

  // Mostly reads on open chains, with opens, stray loads, no-ops and reconfiguration.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned pick, cs_bytes, bps, span;
    logic [14:0] count;
    wait_idle();
    random_config();
    send_item(fccrp_pkg::CMD_OPEN, 12'($urandom), $urandom, 15'($urandom));
    for (int unsigned i = 1; i < n_items; i++) begin
      if (i % 45 == 0) begin
        wait_idle();
        random_config();
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_item(fccrp_pkg::CMD_OPEN, 12'($urandom), $urandom, 15'($urandom));
      end else if (pick < 16) begin
        send_item(fccrp_pkg::CMD_LOAD, 12'($urandom), $urandom, 15'($urandom));
      end else if (pick < 19) begin
        send_item(CMD_NOP, 12'($urandom), $urandom, 15'($urandom));
      end else begin
        bps = 1 << cfg_bps_log2;
        cs_bytes = bps << cfg_spc_log2;
        span = (cs_bytes * 2 > 16384) ? 16384 : cs_bytes * 2;
        pick = $urandom_range(99);
        if (pick < 5) count = '0;
        else if (pick < 45) count = 15'($urandom_range(1, 1024));
        else if (pick < 70) count = 15'($urandom_range(1, span));
        else if (pick < 85) count = 15'(bps * $urandom_range(1, 4));
        else count = 15'($urandom_range(16384, 32767));
        read_bytes(count);
      end
    end
  endtask

  // Result checking and receiver stalls.
  always @(posedge clk_i) begin : result_side
    chunk_t got;
    if (out_valid_o && out_ready_i) begin
      got = {sector_o, sec_skip_o, copy_bytes_o, sector_count_o, staged_o, status_o,
             total_bytes_o, last_o};
      if (chunks_due.size() == 0) begin
        note_mismatch({"unexpected result: ", chunk_text(got)});
      end else begin
        if (got !== chunks_due[0]) begin
          note_mismatch({"result mismatch: expected ", chunk_text(chunks_due[0]),
                         " got ", chunk_text(got)});
        end
        void'(chunks_due.pop_front());
      end
    end
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 37;
    rx_idle_pct = 64;
    test_empty_reads();
    test_chain_walk();
    test_staging_overflow();
    test_config_extremes();
    test_max_results();
    test_backpressure();
    test_random_traffic(60);

    tx_idle_pct = 64;
    rx_idle_pct = 37;
    test_random_traffic(60);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(60);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && chunks_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
